// ===== rtl/two_level_page_table_mapper_macros.svh =====
// Assertion helpers for the page table mapper.
`ifndef TWO_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MAPPER_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every edge outside reset.
`define TPM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never occurs outside reset.
`define TPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/tpm_pkg.sv =====
`default_nettype none
package tpm_pkg;

  localparam int unsigned VA_W       = 32;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned FRAME_W    = 20;
  localparam int unsigned PAGE_SHIFT = 12;
  localparam int unsigned DIR_LSB    = 22;
  localparam int unsigned TBL_LSB    = 12;
  localparam int unsigned TBL_ENTRIES = 1024;
  localparam int unsigned DIR_ENTRIES = 1024;
  // table entry: bit 0 present, bits 20..1 frame
  localparam int unsigned PENT_W     = FRAME_W + 1;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic REQ_MAP   = 1'b0;
  localparam logic REQ_UNMAP = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_POOL_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [VA_W-1:0] freed_addr;
    status_e         status;
  } result_t;

  // memory port strobes
  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/tpm_ram.sv =====
`default_nettype none
module tpm_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 8
) (
  input  wire                      clk_i,
  input  tpm_pkg::mem_ctl_t        ctl_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/tpm_seq.sv =====
`default_nettype none
`include "two_level_page_table_mapper_macros.svh"
module tpm_seq #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  // request
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire                       req_type_i,
  input  wire  [tpm_pkg::VA_W-1:0]  virt_addr_i,
  input  wire  [tpm_pkg::VA_W-1:0]  phys_addr_i,
  // result
  input  wire                       out_free_i,
  output logic                      res_valid_o,
  output tpm_pkg::result_t          res_o,
  // directory memory
  output tpm_pkg::mem_ctl_t         dir_ctl_o,
  output logic [tpm_pkg::IDX_W-1:0] dir_waddr_o,
  output logic [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1):0] dir_wdata_o,
  output logic [tpm_pkg::IDX_W-1:0] dir_raddr_o,
  input  wire  [((TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1):0] dir_rdata_i,
  // table pool memory
  output tpm_pkg::mem_ctl_t         pool_ctl_o,
  output logic [$clog2(TABLE_SLOTS*tpm_pkg::TBL_ENTRIES)-1:0] pool_waddr_o,
  output logic [tpm_pkg::PENT_W-1:0] pool_wdata_o,
  output logic [$clog2(TABLE_SLOTS*tpm_pkg::TBL_ENTRIES)-1:0] pool_raddr_o,
  input  wire  [tpm_pkg::PENT_W-1:0] pool_rdata_i
);

  localparam int unsigned SW     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NW     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned DEPTH  = TABLE_SLOTS * tpm_pkg::TBL_ENTRIES;
  localparam int unsigned PAW    = $clog2(DEPTH);
  localparam int unsigned IW     = tpm_pkg::IDX_W;
  localparam int unsigned FW     = tpm_pkg::FRAME_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIR   = 3'd2;
  localparam logic [2:0] S_TBL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [PAW-1:0]   clr_q, clr_d;
  logic [NW-1:0]    next_q, next_d;
  logic             req_q, req_d;
  logic [IW-1:0]    didx_q, didx_d;
  logic [IW-1:0]    tidx_q, tidx_d;
  logic [FW-1:0]    frame_q, frame_d;
  logic [SW-1:0]    slot_q, slot_d;
  tpm_pkg::result_t res_q, res_d;

  logic             dent_present;
  logic [SW-1:0]    dent_slot;
  logic [SW-1:0]    new_slot;
  logic             pool_full;
  logic             alloc;

  assign dent_present = dir_rdata_i[0];
  assign dent_slot    = dir_rdata_i[SW:1];
  assign new_slot     = SW'(next_q);
  assign pool_full    = (next_q == NW'(TABLE_SLOTS));

  always_comb begin
    state_d      = state_q;
    clr_d        = clr_q;
    next_d       = next_q;
    req_d        = req_q;
    didx_d       = didx_q;
    tidx_d       = tidx_q;
    frame_d      = frame_q;
    slot_d       = slot_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    alloc        = 1'b0;
    dir_ctl_o    = '0;
    dir_waddr_o  = didx_q;
    dir_wdata_o  = '0;
    dir_raddr_o  = virt_addr_i[tpm_pkg::DIR_LSB +: IW];
    pool_ctl_o   = '0;
    pool_waddr_o = PAW'({slot_q, tidx_q});
    pool_wdata_o = '0;
    pool_raddr_o = PAW'({dent_slot, tidx_q});

    unique case (state_q)
      S_CLEAR: begin
        // sweep both stores with zeros, directory wraps inside the pool sweep
        dir_ctl_o.we  = 1'b1;
        dir_waddr_o   = clr_q[IW-1:0];
        pool_ctl_o.we = 1'b1;
        pool_waddr_o  = clr_q;
        clr_d         = clr_q + 1'b1;
        if (clr_q == PAW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dir_ctl_o.re = 1'b1;
          req_d        = req_type_i;
          didx_d       = virt_addr_i[tpm_pkg::DIR_LSB +: IW];
          tidx_d       = virt_addr_i[tpm_pkg::TBL_LSB +: IW];
          frame_d      = phys_addr_i[tpm_pkg::PAGE_SHIFT +: FW];
          state_d      = S_DIR;
        end
      end
      S_DIR: begin
        res_d.freed_addr = '0;
        res_d.status     = tpm_pkg::ST_DONE;
        state_d          = S_OUT;
        if (req_q == tpm_pkg::REQ_MAP) begin
          if (dent_present) begin
            pool_ctl_o.we = 1'b1;
            pool_waddr_o  = PAW'({dent_slot, tidx_q});
            pool_wdata_o  = {frame_q, 1'b1};
          end else if (pool_full) begin
            res_d.status = tpm_pkg::ST_POOL_FULL;
          end else begin
            // hand out the next table, it is already clear
            alloc         = 1'b1;
            dir_ctl_o.we  = 1'b1;
            dir_wdata_o   = {new_slot, 1'b1};
            next_d        = next_q + 1'b1;
            pool_ctl_o.we = 1'b1;
            pool_waddr_o  = PAW'({new_slot, tidx_q});
            pool_wdata_o  = {frame_q, 1'b1};
          end
        end else begin
          if (dent_present) begin
            pool_ctl_o.re = 1'b1;
            slot_d        = dent_slot;
            state_d       = S_TBL;
          end else begin
            res_d.status = tpm_pkg::ST_NOT_MAPPED;
          end
        end
      end
      S_TBL: begin
        state_d = S_OUT;
        if (pool_rdata_i[0]) begin
          pool_ctl_o.we    = 1'b1;
          res_d.freed_addr = {pool_rdata_i[FW:1], {tpm_pkg::PAGE_SHIFT{1'b0}}};
          res_d.status     = tpm_pkg::ST_DONE;
        end else begin
          res_d.freed_addr = '0;
          res_d.status     = tpm_pkg::ST_NOT_MAPPED;
        end
      end
      S_OUT: begin
        if (out_free_i) begin
          res_valid_o = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      next_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      next_q  <= next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    didx_q  <= didx_d;
    tidx_q  <= tidx_d;
    frame_q <= frame_d;
    slot_q  <= slot_d;
    res_q   <= res_d;
  end

  `TPM_ASSERT(a_alloc_step, clk_i, rst_ni, alloc |=> (next_q == $past(next_q) + 1'b1), "slot count did not advance by one")
  `TPM_ASSERT(a_slot_bound, clk_i, rst_ni, (next_q <= NW'(TABLE_SLOTS)), "slot count beyond pool size")
  `TPM_ASSERT_NEVER(a_no_take_clear, clk_i, rst_ni, (state_q == S_CLEAR) && in_ready_o, "request taken during clearing pass")
  `TPM_ASSERT(a_out_then_idle, clk_i, rst_ni, res_valid_o |=> (state_q == S_IDLE), "no return to idle after result")
  `TPM_ASSERT_NEVER(a_idle_no_write, clk_i, rst_ni, (state_q == S_IDLE) && (pool_ctl_o.we || dir_ctl_o.we), "store written while idle")

endmodule
`default_nettype wire

// ===== rtl/two_level_page_table_mapper.sv =====
`default_nettype none
// Two-level page map: a request (tuser 0 = map, 1 = unmap) walks a 1024-entry
// directory held in synchronous RAM and then one entry of a second-level table
// taken from a pool of TABLE_SLOTS tables in a second RAM. Map allocates a table
// on first use of a directory entry and stores the frame; unmap returns the
// frame address and clears the entry. One transaction is processed at a time:
// a map reads the directory, then writes back; an unmap that reaches a table
// reads the directory, then does the dependent table read and clear. The result
// sits in an output register, so the next transaction is accepted while it
// waits. After reset both RAMs are swept with zeros, one pool entry a cycle,
// over the whole pool of TABLE_SLOTS tables; s_axis_tready stays low until
// the sweep is done.
module two_level_page_table_mapper #(
  parameter int unsigned TABLE_SLOTS = 64
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [63:0] s_axis_tdata,  // [31:0] virt_addr, [63:32] phys_addr
  input  wire  [0:0]  s_axis_tuser,  // [0] req_type
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata   // [31:0] freed_addr, [33:32] status, rest zero
);

  localparam int unsigned SW    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned DEPTH = TABLE_SLOTS * tpm_pkg::TBL_ENTRIES;
  localparam int unsigned PAW   = $clog2(DEPTH);

  tpm_pkg::mem_ctl_t          dir_ctl;
  logic [tpm_pkg::IDX_W-1:0]  dir_waddr;
  logic [tpm_pkg::IDX_W-1:0]  dir_raddr;
  logic [SW:0]                dir_wdata;
  logic [SW:0]                dir_rdata;

  tpm_pkg::mem_ctl_t          pool_ctl;
  logic [PAW-1:0]             pool_waddr;
  logic [PAW-1:0]             pool_raddr;
  logic [tpm_pkg::PENT_W-1:0] pool_wdata;
  logic [tpm_pkg::PENT_W-1:0] pool_rdata;

  logic                       out_free;
  logic                       res_valid;
  tpm_pkg::result_t           res;

  logic                       m_valid_q;
  tpm_pkg::result_t           m_res_q;

  // output register is free when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  tpm_seq #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .req_type_i   (s_axis_tuser[0]),
    .virt_addr_i  (s_axis_tdata[31:0]),
    .phys_addr_i  (s_axis_tdata[63:32]),
    .out_free_i   (out_free),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .dir_ctl_o    (dir_ctl),
    .dir_waddr_o  (dir_waddr),
    .dir_wdata_o  (dir_wdata),
    .dir_raddr_o  (dir_raddr),
    .dir_rdata_i  (dir_rdata),
    .pool_ctl_o   (pool_ctl),
    .pool_waddr_o (pool_waddr),
    .pool_wdata_o (pool_wdata),
    .pool_raddr_o (pool_raddr),
    .pool_rdata_i (pool_rdata)
  );

  // directory: bit 0 present, upper bits pool slot
  tpm_ram #(
    .DEPTH (tpm_pkg::DIR_ENTRIES),
    .WIDTH (SW + 1)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .ctl_i   (dir_ctl),
    .waddr_i (dir_waddr),
    .wdata_i (dir_wdata),
    .raddr_i (dir_raddr),
    .rdata_o (dir_rdata)
  );

  // table pool: slot number in the upper address bits, table index below
  tpm_ram #(
    .DEPTH (DEPTH),
    .WIDTH (tpm_pkg::PENT_W)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .ctl_i   (pool_ctl),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  // hold the result until the master side takes the transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (res_valid) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      m_res_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_res_q.status, m_res_q.freed_addr};

endmodule
`default_nettype wire
